>>> rtl/ncfe_pkg.sv
// Shared types, register indexes and helpers for the NFC command frame encoder.
package ncfe_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSTAMBLE = 3'd4;

    localparam logic [BYTE_W-1:0] RST_PREFIX    = 8'h01;
    localparam logic [BYTE_W-1:0] RST_PREAMBLE  = 8'h00;
    localparam logic [BYTE_W-1:0] RST_START     = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_DIRECTION = 8'hD4;
    localparam logic [BYTE_W-1:0] RST_POSTAMBLE = 8'h00;

    localparam logic [BYTE_W-1:0] LEN_MIN = 8'd1;
    localparam logic [BYTE_W-1:0] LEN_MAX = 8'd254;
    localparam logic [BYTE_W-1:0] LEN_SAT = 8'd255;

    typedef struct packed {
        logic [BYTE_W-1:0] prefix;
        logic [BYTE_W-1:0] preamble;
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] direction;
        logic [BYTE_W-1:0] postamble;
    } t_cfg;

    // One classified payload byte, as handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] csum;
    } t_entry;

    function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = v[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

>>> rtl/ncfe_front.sv
// Front part: tracks frame position and checksum, classifies each payload byte.
module ncfe_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_cmd_byte,
    input  logic [7:0]            i_cmd_length,
    input  ncfe_pkg::t_cfg        i_cfg,
    output ncfe_pkg::t_entry      o_entry
);
    import ncfe_pkg::*;

    logic [BYTE_W-1:0] r_left, n_left;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] len_clamped;
    logic [BYTE_W-1:0] left_eff;
    logic [BYTE_W-1:0] sum_base;
    logic              first;

    always_comb begin
        first = (r_left == '0);
        if (i_cmd_length == '0) begin
            len_clamped = LEN_MIN;
        end else if (i_cmd_length == LEN_SAT) begin
            len_clamped = LEN_MAX;
        end else begin
            len_clamped = i_cmd_length;
        end
        left_eff = first ? len_clamped : r_left;
        sum_base = first ? BYTE_W'(i_cfg.preamble + i_cfg.preamble
                                   + i_cfg.start_code + i_cfg.direction)
                         : r_sum;
        n_sum  = BYTE_W'(sum_base + i_cmd_byte);
        n_left = BYTE_W'(left_eff - 8'd1);

        o_entry.data  = i_cmd_byte;
        o_entry.first = first;
        o_entry.last  = (n_left == '0);
        o_entry.len   = BYTE_W'(len_clamped + 8'd1);
        o_entry.csum  = ~n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_sum  <= '0;
        end else if (i_accept) begin
            r_left <= n_left;
            r_sum  <= n_sum;
        end
    end

endmodule

>>> rtl/ncfe_queue.sv
// Short queue of classified payload bytes between the front and the back.
module ncfe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  ncfe_pkg::t_entry  i_wr_entry,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_valid,
    output ncfe_pkg::t_entry  o_rd_entry
);
    import ncfe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp, r_rp;
    logic [CNT_W-1:0]  r_cnt;

    assign o_full     = (r_cnt == FULL_CNT);
    assign o_valid    = (r_cnt != '0);
    assign o_rd_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : PTR_W'(r_wp + 1'b1);
            end
            if (i_rd) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : PTR_W'(r_rp + 1'b1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

>>> rtl/ncfe_back.sv
// Back part: expands each queued byte into header, payload and trailer bytes.
module ncfe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ncfe_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  ncfe_pkg::t_entry  i_entry,
    output logic              o_consume,
    output logic              o_out_vld,
    output logic [7:0]        o_link_byte,
    output logic              o_frame_end,
    input  logic              i_pop
);
    import ncfe_pkg::*;

    localparam logic [3:0] S_PFX   = 4'd0;
    localparam logic [3:0] S_PRE1  = 4'd1;
    localparam logic [3:0] S_PRE2  = 4'd2;
    localparam logic [3:0] S_START = 4'd3;
    localparam logic [3:0] S_LEN   = 4'd4;
    localparam logic [3:0] S_LCS   = 4'd5;
    localparam logic [3:0] S_DIR   = 4'd6;
    localparam logic [3:0] S_DATA  = 4'd7;
    localparam logic [3:0] S_CSUM  = 4'd8;
    localparam logic [3:0] S_POST  = 4'd9;

    logic              r_mid;
    logic [3:0]        r_step;
    logic              r_out_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              r_end;

    logic [3:0]        cur_step;
    logic              advance;
    logic              terminal;
    logic [BYTE_W-1:0] byte_sel;
    logic              end_sel;

    always_comb begin
        cur_step = r_mid ? r_step : (i_entry.first ? S_PFX : S_DATA);
        advance  = i_valid && (!r_out_vld || i_pop);
        terminal = (cur_step == S_POST) || ((cur_step == S_DATA) && !i_entry.last);
        end_sel  = 1'b0;
        unique case (cur_step) inside
            S_PFX:          byte_sel = i_cfg.prefix;
            S_PRE1, S_PRE2: byte_sel = i_cfg.preamble;
            S_START:        byte_sel = i_cfg.start_code;
            S_LEN:          byte_sel = i_entry.len;
            S_LCS:          byte_sel = BYTE_W'(8'd0 - i_entry.len);
            S_DIR:          byte_sel = i_cfg.direction;
            S_DATA:         byte_sel = i_entry.data;
            S_CSUM:         byte_sel = i_entry.csum;
            S_POST: begin
                byte_sel = i_cfg.postamble;
                end_sel  = 1'b1;
            end
            default:        byte_sel = i_entry.data;
        endcase
    end

    assign o_consume   = advance && terminal;
    assign o_out_vld   = r_out_vld;
    assign o_link_byte = r_byte;
    assign o_frame_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid     <= 1'b0;
            r_step    <= S_PFX;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                if (terminal) begin
                    r_mid <= 1'b0;
                end else begin
                    r_mid  <= 1'b1;
                    r_step <= 4'(cur_step + 1'b1);
                end
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Output payload: load on every advance, hold while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte <= rev8(byte_sel);
            r_end  <= end_sel;
        end
    end

endmodule

>>> rtl/nfc_command_frame_encoder_unit.sv
// Top level of the NFC command frame encoder: register file and front/back wiring.
//
// Usage: command payload bytes enter on the push/full side, one transaction per
// byte, with i_cmd_length sampled on the first byte of each command only (0 is
// taken as 1, 255 as 254). Link bytes leave on the empty/pop side, bit-reversed
// for LSB-first transmission; o_frame_end marks the postamble.
// A command's first byte yields 8 link bytes (prefix, two preambles, start code,
// LEN, LCS, direction, payload), middle bytes yield 1, and the last byte adds
// the data checksum and postamble; a one-byte command yields 10.
// A pushed byte is stored in the queue and then loaded into the back output
// register before its first link byte can be popped.
// Throughput: one link byte per cycle while bytes are queued and pop keeps up, set
// by the back sequencer and its single output register; the input side takes one
// byte per cycle while the queue of QUEUE_DEPTH classified bytes has room.
// Configuration registers are written through i_cfg_wr/i_cfg_idx/i_cfg_wdata
// while the block is idle; unused indexes are ignored.
// Reset clears frame position, checksum, queue and output valid flag and loads
// the default register values. When pop is held low the current link byte
// holds, the back part stops, and full rises once the queue fills.
module nfc_command_frame_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_cmd_byte,
    input  logic [7:0]  i_cmd_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_link_byte,
    output logic        o_frame_end,
    input  logic        i_cfg_wr,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import ncfe_pkg::*;

    t_cfg    r_cfg;
    t_entry  fe_entry;
    t_entry  q_entry;
    logic    q_full;
    logic    q_valid;
    logic    q_rd;
    logic    accept;
    logic    out_vld;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix     <= RST_PREFIX;
            r_cfg.preamble   <= RST_PREAMBLE;
            r_cfg.start_code <= RST_START;
            r_cfg.direction  <= RST_DIRECTION;
            r_cfg.postamble  <= RST_POSTAMBLE;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_idx)
                CFG_PREFIX:    r_cfg.prefix     <= i_cfg_wdata;
                CFG_PREAMBLE:  r_cfg.preamble   <= i_cfg_wdata;
                CFG_START:     r_cfg.start_code <= i_cfg_wdata;
                CFG_DIRECTION: r_cfg.direction  <= i_cfg_wdata;
                CFG_POSTAMBLE: r_cfg.postamble  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ncfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd_byte   (i_cmd_byte),
        .i_cmd_length (i_cmd_length),
        .i_cfg        (r_cfg),
        .o_entry      (fe_entry)
    );

    ncfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (accept),
        .i_wr_entry (fe_entry),
        .o_full     (q_full),
        .i_rd       (q_rd),
        .o_valid    (q_valid),
        .o_rd_entry (q_entry)
    );

    ncfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_consume   (q_rd),
        .o_out_vld   (out_vld),
        .o_link_byte (o_link_byte),
        .o_frame_end (o_frame_end),
        .i_pop       (pop)
    );

endmodule

>>> rtl/ncfe_checker.sv
// Port-level checks for the NFC command frame encoder, bound to the top level.
module ncfe_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_link_byte,
    input  logic        o_frame_end
);

    // Reset drains the output side.
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // Reset drains the queue.
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("queue full after reset");

    // Hold the link byte while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_link_byte) && $stable(o_frame_end)))
        else $error("link byte changed while stalled");

    // A postamble is followed by a new frame prefix, never by another postamble.
    a_no_double_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_frame_end) |=> (empty || !o_frame_end))
        else $error("two frame ends in a row");

endmodule

bind nfc_command_frame_encoder_unit ncfe_checker u_ncfe_checker (.*);
